>>> rtl/hms_pkg.sv
// Shared types and constants for the in-place height-map smoother.
// Used by every module of the block; depends on nothing.
`default_nettype none
package hms_pkg;

  // Fixed field widths of the stream items.
  localparam int CMD_W      = 2;
  localparam int ADDR_W     = 9;
  localparam int VAL_W      = 16;
  localparam int IN_DATA_W  = 40;  // 36 bits of fields, padded to whole bytes
  localparam int OUT_DATA_W = 24;  // 17 bits of fields, padded to whole bytes

  // Configuration registers.
  localparam int CFG_W       = 10;
  localparam int CFG_ADDR_W  = 1;
  localparam int DIM_W       = 13;  // holds any dimension up to the largest map
  localparam logic [CFG_ADDR_W-1:0] REG_ROWS = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_COLS = 1'b1;
  localparam logic [CFG_W-1:0] DIM_RESET = 10'd512;

  // Defaults of the top-level parameters.
  localparam int DEF_MAX_ROWS    = 512;
  localparam int DEF_MAX_COLS    = 512;
  localparam int DEF_HEIGHT_BITS = 16;

  // Smoothing weights: the centre counts twice, the sum is divided by ten.
  localparam int DIVISOR = 10;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_PASS  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    OUT_ZERO,
    OUT_READ,
    OUT_PASS
  } out_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HOST_RD,
    ST_PASS_RD,
    ST_PASS_ACC,
    ST_PASS_DIVS,
    ST_PASS_DIVW,
    ST_PASS_WR,
    ST_PASS_END
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic      host_wr;
    logic      host_rd;
    logic      pass_init;
    logic      tap_rd;
    logic      div_start;
    logic      res_wr;
    logic      out_load;
    out_kind_t out_kind;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic dims_small;
    logic tap_last;
    logic pos_last;
    logic div_done;
    logic out_busy;
  } dp_stat_t;

endpackage
`default_nettype wire

>>> rtl/hms_div.sv
// Divider by the constant ten: the dividend is registered, then multiplied by a
// scaled reciprocal; done rises together with the registered quotient. Depends on hms_pkg.
`default_nettype none
module hms_div #(
  parameter int SUM_W = 20
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [SUM_W-1:0] dividend,
  output logic                  done,
  output logic [SUM_W-1:0]      quotient
);
  import hms_pkg::*;

  // The reciprocal is rounded up; its error times any SUM_W-bit dividend stays
  // below one unit of the shifted product, so the floor is exact.
  localparam int SHIFT = SUM_W + 4;
  localparam logic [SUM_W:0] RECIP =
    (SUM_W+1)'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  logic [SUM_W-1:0] num_r, num_nxt;
  logic [SUM_W-1:0] quo_r, quo_nxt;
  logic             stage_r, stage_nxt;
  logic             done_r, done_nxt;
  logic [2*SUM_W:0] prod;

  assign prod = num_r * RECIP;

  always_comb begin
    num_nxt   = start ? dividend : num_r;
    stage_nxt = start;
    quo_nxt   = stage_r ? SUM_W'(prod[2*SUM_W:SHIFT]) : quo_r;
    if (start) begin
      done_nxt = 1'b0;
    end else if (stage_r) begin
      done_nxt = 1'b1;
    end else begin
      done_nxt = done_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      stage_r <= stage_nxt;
      done_r  <= done_nxt;
    end
    num_r <= num_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

>>> rtl/hms_dp.sv
// Datapath: height memory, window walker, accumulator, divider and result register.
// Depends on hms_pkg and hms_div.
`default_nettype none
module hms_dp #(
  parameter int MAX_ROWS    = 512,
  parameter int MAX_COLS    = 512,
  parameter int HEIGHT_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [hms_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [hms_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire logic [hms_pkg::ADDR_W-1:0]    in_row,
  input  wire logic [hms_pkg::ADDR_W-1:0]    in_col,
  input  wire logic [hms_pkg::VAL_W-1:0]     in_value,
  input  wire hms_pkg::dp_cmd_t              cmd,
  output hms_pkg::dp_stat_t                  stat,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [hms_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import hms_pkg::*;

  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int MADR_W = ROW_W + COL_W;
  localparam int DEPTH  = 1 << MADR_W;
  localparam int SUM_W  = HEIGHT_BITS + 4;

  logic [CFG_W-1:0] rows_r, cols_r;
  logic [DIM_W-1:0] eff_rows, eff_cols;

  logic [HEIGHT_BITS-1:0] mem [DEPTH];
  logic [HEIGHT_BITS-1:0] rdata_r;

  logic [ROW_W-1:0] ci_r;
  logic [COL_W-1:0] cj_r;
  logic [1:0]       tr_r, tc_r;
  logic             acc_v_r, dbl_r, ok_r;
  logic [SUM_W-1:0] acc_r;
  logic             out_valid_r;
  logic [VAL_W-1:0] out_val_r;
  logic             out_done_r;

  logic              host_ok, row_last, col_last;
  logic              we;
  logic [MADR_W-1:0] waddr, raddr;
  logic [HEIGHT_BITS-1:0] wdata;
  logic [ROW_W-1:0]  tap_row;
  logic [COL_W-1:0]  tap_col;
  logic [SUM_W-1:0]  quotient;
  logic              div_done;

  // Dimensions above the map size act as the map size.
  assign eff_rows = (DIM_W'(rows_r) > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : DIM_W'(rows_r);
  assign eff_cols = (DIM_W'(cols_r) > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : DIM_W'(cols_r);

  assign host_ok  = (DIM_W'(in_row) < eff_rows) && (DIM_W'(in_col) < eff_cols);
  assign row_last = DIM_W'(ci_r) == eff_rows - DIM_W'(2);
  assign col_last = DIM_W'(cj_r) == eff_cols - DIM_W'(2);

  assign tap_row = ci_r + ROW_W'(tr_r) - ROW_W'(1);
  assign tap_col = cj_r + COL_W'(tc_r) - COL_W'(1);

  assign we    = (cmd.host_wr && host_ok) || cmd.res_wr;
  assign waddr = cmd.res_wr ? {ci_r, cj_r} : {ROW_W'(in_row), COL_W'(in_col)};
  assign wdata = cmd.res_wr ? HEIGHT_BITS'(quotient) : HEIGHT_BITS'(in_value);
  assign raddr = cmd.tap_rd ? {tap_row, tap_col} : {ROW_W'(in_row), COL_W'(in_col)};

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.tap_rd || cmd.host_rd) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= DIM_RESET;
      cols_r <= DIM_RESET;
    end else if (cfg_we) begin
      if (cfg_addr == REG_ROWS) begin
        rows_r <= cfg_wdata;
      end else begin
        cols_r <= cfg_wdata;
      end
    end
  end

  // Window walker: the centre moves in raster order, the nine taps row by row.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_v_r <= 1'b0;
    end else begin
      acc_v_r <= cmd.tap_rd;
    end
    dbl_r <= (tr_r == 2'd1) && (tc_r == 2'd1);
    if (cmd.host_rd) begin
      ok_r <= host_ok;
    end
    if (cmd.pass_init) begin
      ci_r <= ROW_W'(1);
      cj_r <= COL_W'(1);
    end else if (cmd.res_wr) begin
      if (col_last) begin
        cj_r <= COL_W'(1);
        ci_r <= ci_r + 1'b1;
      end else begin
        cj_r <= cj_r + 1'b1;
      end
    end
    if (cmd.pass_init || cmd.res_wr) begin
      tr_r  <= '0;
      tc_r  <= '0;
      acc_r <= '0;
    end else begin
      if (cmd.tap_rd) begin
        if (tc_r == 2'd2) begin
          tc_r <= '0;
          tr_r <= tr_r + 1'b1;
        end else begin
          tc_r <= tc_r + 1'b1;
        end
      end
      if (acc_v_r) begin
        acc_r <= acc_r + (dbl_r ? SUM_W'({rdata_r, 1'b0}) : SUM_W'(rdata_r));
      end
    end
  end

  hms_div #(.SUM_W(SUM_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (acc_r),
    .done     (div_done),
    .quotient (quotient)
  );

  // Result register: loaded only when empty or being emptied.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_val_r  <= ((cmd.out_kind == OUT_READ) && ok_r) ? VAL_W'(rdata_r) : '0;
      out_done_r <= cmd.out_kind == OUT_PASS;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - VAL_W - 1){1'b0}}, out_done_r, out_val_r};

  assign stat.dims_small = (eff_rows < DIM_W'(3)) || (eff_cols < DIM_W'(3));
  assign stat.tap_last   = (tr_r == 2'd2) && (tc_r == 2'd2);
  assign stat.pos_last   = row_last && col_last;
  assign stat.div_done   = div_done;
  assign stat.out_busy   = out_valid_r && !out_tready;

  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.host_wr && cmd.res_wr))
    else $error("host write and smoothed write in the same cycle");
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("result register overwritten while still held");
  a_res_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_wr |-> div_done)
    else $error("smoothed sample written before the divider finished");
  a_div_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> !div_done)
    else $error("divider still reports done after a new start");

endmodule
`default_nettype wire

>>> rtl/hms_ctrl.sv
// Controller state machine: sequences host accesses and the smoothing pass.
// Depends on hms_pkg.
`default_nettype none
module hms_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  input  wire logic [hms_pkg::CMD_W-1:0] in_cmd,
  input  wire hms_pkg::dp_stat_t        stat,
  output hms_pkg::dp_cmd_t              cmd
);
  import hms_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.out_kind = OUT_ZERO;
    in_tready    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = !stat.out_busy;
        if (in_tvalid && !stat.out_busy) begin
          unique case (in_cmd)
            CMD_WRITE: begin
              cmd.host_wr  = 1'b1;
              cmd.out_load = 1'b1;
            end
            CMD_PASS: begin
              cmd.pass_init = 1'b1;
              state_nxt     = stat.dims_small ? ST_PASS_END : ST_PASS_RD;
            end
            CMD_READ: begin
              cmd.host_rd = 1'b1;
              state_nxt   = ST_HOST_RD;
            end
            default: begin
              cmd.out_load = 1'b1;
            end
          endcase
        end
      end
      ST_HOST_RD: begin
        cmd.out_load = 1'b1;
        cmd.out_kind = OUT_READ;
        state_nxt    = ST_IDLE;
      end
      ST_PASS_RD: begin
        cmd.tap_rd = 1'b1;
        if (stat.tap_last) begin
          state_nxt = ST_PASS_ACC;
        end
      end
      ST_PASS_ACC: begin
        state_nxt = ST_PASS_DIVS;
      end
      ST_PASS_DIVS: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_PASS_DIVW;
      end
      ST_PASS_DIVW: begin
        if (stat.div_done) begin
          state_nxt = ST_PASS_WR;
        end
      end
      ST_PASS_WR: begin
        cmd.res_wr = 1'b1;
        state_nxt  = stat.pos_last ? ST_PASS_END : ST_PASS_RD;
      end
      ST_PASS_END: begin
        cmd.out_load = 1'b1;
        cmd.out_kind = OUT_PASS;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/inplace_heightmap_smoother_unit.sv
// Top level of the in-place 3x3 height-map smoother.
// Depends on hms_pkg, hms_ctrl and hms_dp (which holds hms_div).
// Writes and other non-pass items are handled in the idle state; a read also
// goes through the host-read state. A pass visits each interior sample: nine reads
// through the single memory read port, finishing the sum, starting and awaiting the
// divide by ten, and the write-back. Reset (rst_n, synchronous) empties the result
// register, idles the controller, sets both dimensions to 512; memory is not cleared.
`default_nettype none
module inplace_heightmap_smoother_unit #(
  parameter int MAX_ROWS    = hms_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS    = hms_pkg::DEF_MAX_COLS,
  parameter int HEIGHT_BITS = hms_pkg::DEF_HEIGHT_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Configuration write port: index 0 is rows_in_use, index 1 is cols_in_use.
  input  wire logic                           cfg_we,
  input  wire logic [hms_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [hms_pkg::CFG_W-1:0]      cfg_wdata,
  // Input items.
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // From bit 0: cmd[1:0], row[10:2], col[19:11], value[35:20], zero padding.
  input  wire logic [hms_pkg::IN_DATA_W-1:0]  in_tdata,
  // Result items.
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // From bit 0: read_value[15:0], pass_done[16], zero padding.
  output logic [hms_pkg::OUT_DATA_W-1:0]      out_tdata
);
  import hms_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The controller only needs the command; addresses and data go to the datapath.
  hms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (in_tdata[1:0]),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath walks the 3x3 window over the memory in raster order, so each
  // window already sees the smoothed samples above and to the left.
  hms_dp #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLS    (MAX_COLS),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_row     (in_tdata[10:2]),
    .in_col     (in_tdata[19:11]),
    .in_value   (in_tdata[35:20]),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire
